@@ hdl/tld_pkg.sv @@
// tld_pkg: shared constants, register indexes and the chain control struct
// for the tty line discipline. No dependencies.
package tld_pkg;

  localparam int LINE_MAX_DEF = 32;
  localparam int LIMIT_W      = 6;

  localparam logic [7:0] BS_CHAR = 8'h7f;
  localparam logic [7:0] NL_CHAR = 8'h0a;
  localparam logic [7:0] CR_CHAR = 8'h0d;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 6'd32;
  localparam logic               ECHO_RST  = 1'b1;
  localparam logic               ICR_RST   = 1'b1;
  localparam logic               CRLF_RST  = 1'b1;

  typedef enum logic [1:0] {
    REG_LINE_LIMIT  = 2'd0,
    REG_ECHO_ENABLE = 2'd1,
    REG_INPUT_CR    = 2'd2,
    REG_OUTPUT_CRLF = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic wr0_en;
    logic wr1_en;
    logic shift;
  } chain_ctl_t;

endpackage

@@ hdl/tld_cell.sv @@
// tld_cell: one character slot of the line chain.
// Loads a new character or takes its neighbor's on a shift; uses tld_pkg.
module tld_cell
  import tld_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  logic [7:0] load_data,
  input  logic       shift,
  input  logic [7:0] next_data,
  output logic [7:0] data
);

  logic [7:0] data_r;

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end else if (shift) begin
      data_r <= next_data;
    end
  end

  assign data = data_r;

endmodule

@@ hdl/tld_chain.sv @@
// tld_chain: row of tld_cell slots holding the buffered line.
// Writes at the line end, shifts toward slot 0 while draining; uses tld_pkg.
module tld_chain
  import tld_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF,
  localparam int IW = $clog2(LINE_MAX)
) (
  input  logic          clk,
  input  chain_ctl_t    ctl,
  input  logic [IW-1:0] wr0_idx,
  input  logic [7:0]    wr0_data,
  input  logic [IW-1:0] wr1_idx,
  output logic [7:0]    head_char
);

  logic [7:0] slot [LINE_MAX];

  for (genvar i = 0; i < LINE_MAX; i++) begin : g_slot
    logic       ld0;
    logic       ld1;
    logic [7:0] nxt;

    assign ld0 = ctl.wr0_en && (wr0_idx == IW'(i));
    assign ld1 = ctl.wr1_en && (wr1_idx == IW'(i));
    if (i == LINE_MAX - 1) begin : g_end
      assign nxt = slot[i];
    end else begin : g_mid
      assign nxt = slot[i+1];
    end

    tld_cell u_cell (
      .clk       (clk),
      .load      (ld0 || ld1),
      .load_data (ld0 ? wr0_data : NL_CHAR),
      .shift     (ctl.shift),
      .next_data (nxt),
      .data      (slot[i])
    );
  end

  assign head_char = slot[0];

endmodule

@@ hdl/tty_line_discipline.sv @@
// tty_line_discipline: canonical line assembly with echo, top level.
// Uses tld_pkg and tld_chain (row of tld_cell slots).
//
//   channel  ports                           direction  transfer when
//   input    in_valid in_stall in_rx_char    in         in_valid && !in_stall
//   result   out_valid out_stall out_kind    out        out_valid && !out_stall
//            out_char out_last
//   config   psel penable pwrite paddr       in/out     psel && penable && pwrite
//            pwdata prdata pready
//
// An input character is taken while in_stall is low; its results then leave
// one per cycle from the output register: up to two echo characters, then the
// line drained from slot 0 of the chain. The next input is taken once the last
// result has been loaded. Reset clears the line length, pending results and
// config registers; slots keep their data. A stalled output holds its result
// and the sequence pauses.
module tty_line_discipline
  import tld_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_char,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int IW = $clog2(LINE_MAX);
  localparam int CW = 7;

  logic [LIMIT_W-1:0] limit_r;
  logic               echo_r;
  logic               icr_r;
  logic               crlf_r;
  logic [LW-1:0]      len_r;
  logic [LW-1:0]      len_nxt;
  logic               echo_cr_r;
  logic               echo_cr_nxt;
  logic               echo_ch_r;
  logic               echo_ch_nxt;
  logic [7:0]         echo_char_r;
  logic [LW-1:0]      drain_r;
  logic [LW-1:0]      drain_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_kind_r;
  logic               out_kind_nxt;
  logic [7:0]         out_char_r;
  logic [7:0]         out_char_nxt;
  logic               out_last_r;
  logic               out_last_nxt;

  logic          busy;
  logic          acc;
  logic          out_load;
  logic          cfg_wr;
  reg_idx_t      cfg_idx;
  logic [CW-1:0] lim;
  logic [CW-1:0] len7;
  logic [CW-1:0] new7;
  logic          is_bs;
  logic          is_nl;
  logic          is_cr;
  logic          bs_empty;
  logic          cr_ins;
  logic          room;
  logic          deliver;
  chain_ctl_t    ctl;
  logic [7:0]    wr0_data;
  logic [7:0]    head_char;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      echo_r  <= ECHO_RST;
      icr_r   <= ICR_RST;
      crlf_r  <= CRLF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LINE_LIMIT:  limit_r <= pwdata[LIMIT_W-1:0];
        REG_ECHO_ENABLE: echo_r  <= pwdata[0];
        REG_INPUT_CR:    icr_r   <= pwdata[0];
        REG_OUTPUT_CRLF: crlf_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LINE_LIMIT:  prdata = {{(32-LIMIT_W){1'b0}}, limit_r};
      REG_ECHO_ENABLE: prdata = {31'd0, echo_r};
      REG_INPUT_CR:    prdata = {31'd0, icr_r};
      REG_OUTPUT_CRLF: prdata = {31'd0, crlf_r};
      default:         prdata = 32'd0;
    endcase
  end

  // effective limit, saturated to 1..LINE_MAX
  always_comb begin
    if (limit_r == '0) begin
      lim = CW'(1);
    end else if ({1'b0, limit_r} > CW'(LINE_MAX)) begin
      lim = CW'(LINE_MAX);
    end else begin
      lim = {1'b0, limit_r};
    end
  end

  // input character decode
  assign busy     = echo_cr_r || echo_ch_r || (drain_r != '0);
  assign in_stall = busy;
  assign acc      = in_valid && !busy;

  assign len7     = CW'(len_r);
  assign is_bs    = (in_rx_char == BS_CHAR);
  assign is_nl    = (in_rx_char == NL_CHAR);
  assign is_cr    = (in_rx_char == CR_CHAR);
  assign bs_empty = is_bs && (len_r == '0);
  assign room     = (len7 < CW'(LINE_MAX));
  assign cr_ins   = is_nl && icr_r && ((len7 + CW'(1)) < lim) && room;

  always_comb begin
    if (is_bs) begin
      new7 = bs_empty ? len7 : len7 - CW'(1);
    end else if (room) begin
      new7 = len7 + CW'(1) + CW'(cr_ins);
    end else begin
      new7 = len7;
    end
  end

  assign deliver  = !bs_empty && (is_nl || is_cr || (new7 >= lim));
  assign wr0_data = cr_ins ? CR_CHAR : in_rx_char;

  // result sequencer
  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    len_nxt       = len_r;
    echo_cr_nxt   = echo_cr_r;
    echo_ch_nxt   = echo_ch_r;
    drain_nxt     = drain_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctl.wr0_en    = 1'b0;
    ctl.wr1_en    = 1'b0;
    ctl.shift     = 1'b0;

    if (out_load) begin
      out_valid_nxt = 1'b0;
      if (echo_cr_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b0;
        out_char_nxt  = CR_CHAR;
        out_last_nxt  = !echo_ch_r && (drain_r == '0);
        echo_cr_nxt   = 1'b0;
      end else if (echo_ch_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b0;
        out_char_nxt  = echo_char_r;
        out_last_nxt  = (drain_r == '0);
        echo_ch_nxt   = 1'b0;
      end else if (drain_r != '0) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = 1'b1;
        out_char_nxt  = head_char;
        out_last_nxt  = (drain_r == LW'(1));
        drain_nxt     = drain_r - LW'(1);
        ctl.shift     = 1'b1;
      end
    end

    if (acc && !bs_empty) begin
      ctl.wr0_en  = !is_bs && room;
      ctl.wr1_en  = cr_ins;
      echo_ch_nxt = echo_r;
      echo_cr_nxt = echo_r && is_nl && crlf_r;
      len_nxt     = deliver ? '0 : LW'(new7);
      drain_nxt   = deliver ? LW'(new7) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      echo_cr_r   <= 1'b0;
      echo_ch_r   <= 1'b0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r       <= len_nxt;
      echo_cr_r   <= echo_cr_nxt;
      echo_ch_r   <= echo_ch_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      echo_char_r <= in_rx_char;
    end
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  tld_chain #(
    .LINE_MAX (LINE_MAX)
  ) u_chain (
    .clk       (clk),
    .ctl       (ctl),
    .wr0_idx   (len_r[IW-1:0]),
    .wr0_data  (wr0_data),
    .wr1_idx   (IW'(len_r + LW'(1))),
    .head_char (head_char)
  );

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule
